### hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition that must never be seen on a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

### hdl/csc_pkg.sv
// package with shared constants and types of the cordic sine and cosine core
`default_nettype none
package csc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ITER_W      = 6;
  localparam int unsigned ROM_WORDS   = 32;
  localparam int unsigned MAX_STAGES_DEF = 32;
  localparam int unsigned ADDR_W      = 2;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [ADDR_W-1:0] REG_ITERATIONS = 2'd0;
  localparam logic [ITER_W-1:0] ITER_RESET = 6'd32;
  localparam logic [DATA_W-1:0] GAIN_INIT  = 32'h26DD3B6A;

  localparam logic [DATA_W-1:0] ATAN_ROM [ROM_WORDS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } vec_t;

endpackage
`default_nettype wire

### hdl/csc_cell.sv
// one cordic micro-rotation cell with its own request and vector registers
`default_nettype none
module csc_cell
  import csc_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ITER_W-1:0] n_i,
  input  wire logic              valid_i,
  input  wire vec_t              vec_i,
  output logic                   valid_o,
  output vec_t                   vec_o
);

  localparam logic [ITER_W-1:0] IDX_C = ITER_W'(IDX);
  localparam logic [DATA_W-1:0] ANGLE = ATAN_ROM[IDX];

  logic  valid_q;
  vec_t  vec_q, vec_d;
  logic [DATA_W-1:0] xs, ys;

  assign xs = DATA_W'($signed(vec_i.x) >>> IDX);
  assign ys = DATA_W'($signed(vec_i.y) >>> IDX);

  always_comb begin
    vec_d = vec_i;
    if (IDX_C < n_i) begin
      if (vec_i.z[DATA_W-1]) begin
        vec_d.x = vec_i.x + ys;
        vec_d.y = vec_i.y - xs;
        vec_d.z = vec_i.z + ANGLE;
      end else begin
        vec_d.x = vec_i.x - ys;
        vec_d.y = vec_i.y + xs;
        vec_d.z = vec_i.z - ANGLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule
`default_nettype wire

### hdl/cordic_sine_cosine_core.sv
// cordic sine and cosine core: register port and chain of rotation cells
//
// usage
//   requests enter on start with angle_i (signed q2.30 radians, meaningful
//   within -pi/2..pi/2). busy stays low, so a request is taken every cycle.
//   each request moves one cell per cycle through MAX_STAGES rotation cells;
//   cells at or above the iteration count pass the vector on unchanged.
//   the result shows on sine_o and cosine_o (q2.30) with done_o high for one
//   cycle, once the request has passed through every cell register.
//   throughput is one request per cycle.
//   results appear in request order and cannot be held off by the receiver.
//   the apb port holds iterations at address 0 (bits 5:0); counts above
//   MAX_STAGES act as MAX_STAGES. write it only while no request is in flight.
//   reset empties the chain and sets iterations to 32.
`default_nettype none
`include "assert_macros.svh"
module cordic_sine_cosine_core
  import csc_pkg::*;
#(
  parameter int unsigned MAX_STAGES = MAX_STAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [DATA_W-1:0] angle_i,
  output logic                    done_o,
  output logic signed [DATA_W-1:0] sine_o,
  output logic signed [DATA_W-1:0] cosine_o
);

  localparam logic [ITER_W-1:0] MAX_N = ITER_W'(MAX_STAGES);

  logic [ITER_W-1:0] iterations_q;
  logic [ITER_W-1:0] n_clamp;
  logic              cfg_wr;

  logic valid_c [MAX_STAGES+1];
  vec_t vec_c   [MAX_STAGES+1];

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iterations_q <= ITER_RESET;
    end else if (cfg_wr && (paddr == REG_ITERATIONS)) begin
      iterations_q <= pwdata[ITER_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_ITERATIONS) begin
      prdata = {{(PDATA_W-ITER_W){1'b0}}, iterations_q};
    end
  end

  assign n_clamp = (iterations_q > MAX_N) ? MAX_N : iterations_q;

  assign valid_c[0]   = start && !busy;
  assign vec_c[0].x   = GAIN_INIT;
  assign vec_c[0].y   = '0;
  assign vec_c[0].z   = angle_i;

  for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
    csc_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .n_i    (n_clamp),
      .valid_i(valid_c[k]),
      .vec_i  (vec_c[k]),
      .valid_o(valid_c[k+1]),
      .vec_o  (vec_c[k+1])
    );
  end

  assign done_o   = valid_c[MAX_STAGES];
  assign sine_o   = vec_c[MAX_STAGES].y;
  assign cosine_o = vec_c[MAX_STAGES].x;

  `ASSERT_CLK(a_done_follows_req, clk_i, rst_ni, done_o |-> $past(start, MAX_STAGES))
  `ASSERT_CLK(a_req_gives_done, clk_i, rst_ni, (start && !busy) |-> ##MAX_STAGES done_o)
  `ASSERT_CLK(a_cfg_write_lands, clk_i, rst_ni,
    (cfg_wr && (paddr == REG_ITERATIONS)) |=> (iterations_q == $past(pwdata[ITER_W-1:0])))
  `ASSERT_NEVER(a_busy_never, clk_i, rst_ni, busy)

endmodule
`default_nettype wire

### bench/tb.sv
// testbench for the cordic sine and cosine core: angle requests against a bit-exact rotation model
`timescale 1ns / 1ps
module tb;
  import csc_pkg::*;

  localparam int          STAGES      = 32;
  localparam int          LATENCY     = STAGES;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [31:0] GAIN        = 32'h26DD3B6A;
  localparam logic [31:0] HALF_PI     = 32'h6487ED51;
  localparam logic [31:0] QUARTER_PI  = 32'h3243F6A8;

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [31:0] sine;
    logic [31:0] cosine;
  } sincos_t;

  logic                      clk_i   = 1'b0;
  logic                      rst_ni  = 1'b0;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [ADDR_W-1:0]         paddr   = '0;
  logic [PDATA_W-1:0]        pwdata  = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      start   = 1'b0;
  logic                      busy;
  logic signed [DATA_W-1:0]  angle_i = '0;
  logic                      done_o;
  logic signed [DATA_W-1:0]  sine_o;
  logic signed [DATA_W-1:0]  cosine_o;

  logic [31:0] angle_backlog [$];
  sincos_t     sincos_due [$];
  logic [5:0]  iter_count = 6'd32;
  int          idle_pct   = 0;
  logic        req_taken  = 1'b0;
  int          cycles     = 0;
  int          mismatches = 0;

  cordic_sine_cosine_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .busy     (busy),
    .angle_i  (angle_i),
    .done_o   (done_o),
    .sine_o   (sine_o),
    .cosine_o (cosine_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic sincos_t cordic_rotate(input logic [31:0] angle, input logic [5:0] iters);
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    int                 n;
    sincos_t            res;
    x = GAIN;
    y = '0;
    z = angle;
    n = (iters > STAGES) ? STAGES : int'(iters);
    for (int k = 0; k < n; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z[31]) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TABLE[k];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TABLE[k];
      end
    end
    res.sine   = y;
    res.cosine = x;
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s at cycle %0d: expected %h, got %h", what, cycles, want, got);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!start || req_taken) begin
      if (angle_backlog.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        start   <= 1'b1;
        angle_i <= angle_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    sincos_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cordic_sine_cosine_core test failed");
      $finish;
    end else begin
      req_taken <= rst_ni && start && !busy;
      if (rst_ni && done_o) begin
        if (sincos_due.size() == 0) begin
          report("unexpected sine", '0, sine_o);
        end else begin
          want = sincos_due.pop_front();
          if (want.sine !== sine_o)
            report("sine", want.sine, sine_o);
          if (want.cosine !== cosine_o)
            report("cosine", want.cosine, cosine_o);
        end
      end
      if (rst_ni && start && !busy)
        sincos_due.push_back(cordic_rotate(angle_i, iter_count));
    end
  end

  task automatic read_iterations(input logic [5:0] want);
    logic [PDATA_W-1:0] rd;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = REG_ITERATIONS;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd[ITER_W-1:0] !== want)
      report("iterations readback", {26'b0, want}, rd);
  endtask

  task automatic write_iterations(input logic [5:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_ITERATIONS;
    pwdata  = {26'b0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    iter_count = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    read_iterations(value);
  endtask

  task automatic drain();
    while (angle_backlog.size() != 0 || start || sincos_due.size() != 0)
      @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  logic [5:0] phase_iters [7] = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd16, 6'd33, 6'd32};
  int         phase_idle  [7] = '{0, 81, 0, 14, 81, 14, 0};

  initial begin
    logic [31:0] a;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    read_iterations(6'd32);

    // directed angles at the reset count
    angle_backlog = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                      HALF_PI, -HALF_PI, QUARTER_PI, -QUARTER_PI, 32'h20000000,
                      32'hAAAAAAAA, 32'h55555555};
    drain();
    write_iterations(6'd0);
    angle_backlog = '{32'h12345678, 32'h80000000};
    drain();
    write_iterations(6'd1);
    angle_backlog = '{HALF_PI, 32'hFFFFFFFF, 32'h0};
    drain();
    write_iterations(6'd63);
    angle_backlog = '{QUARTER_PI, -QUARTER_PI, 32'h7FFFFFFF};
    drain();
    write_iterations(6'd33);
    angle_backlog = '{-HALF_PI};
    drain();

    for (int p = 0; p < 7; p++) begin
      write_iterations((p == 6) ? 6'($urandom_range(63, 0)) : phase_iters[p]);
      idle_pct = phase_idle[p];
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(99, 0) < 85)
          a = $urandom_range(32'd3373259426, 0) - HALF_PI;
        else
          a = $urandom;
        angle_backlog.push_back(a);
      end
      drain();
    end
    write_iterations(6'd32);

    if (sincos_due.size() != 0)
      report("leftover results", 32'd0, sincos_due.size());
    if (mismatches == 0)
      $display("cordic_sine_cosine_core test passed");
    else
      $display("cordic_sine_cosine_core test failed");
    $finish;
  end

endmodule
